// ===== hdl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the collision push-apart pipeline.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int W         = 32;   // coordinate width
  localparam int REACH_W   = 31;   // radius width
  localparam int SQ_W      = 64;   // squared length width
  localparam int LEN_W     = 32;   // vector length width
  localparam int DEN_W     = LEN_W + 1;
  localparam int Q_W       = 33;   // quotient bits kept before saturation
  localparam int NUM_W     = 64;
  localparam int FRONT_LAT = 3;
  localparam int SQRT_LAT  = SQ_W / 2;
  localparam int MID_LAT   = 3;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int LATENCY   = FRONT_LAT + SQRT_LAT + MID_LAT + DIV_LAT + 1;

  localparam logic [1:0] REQ_SPHERE     = 2'd0;
  localparam logic [1:0] REQ_BOX        = 2'd1;
  localparam logic [1:0] REQ_SPHERE_BOX = 2'd2;
  localparam logic [1:0] REQ_NONE       = 2'd3;

  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic en_a;
    logic en_b;
    logic shared;
    logic box;
    logic fallback;
    logic skip;
  } ctl_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic [2:0]            neg;
    logic [2:0][W-1:0]     mag;
    logic [REACH_W-1:0]    reach;
  } item_t;

  typedef struct packed {
    logic sgn;   // sign of the push for object b
    logic en_a;
    logic en_b;
    logic skip;
  } tag_t;

endpackage

// ===== hdl/cpa_front.sv =====
// ----------------------------------------------------------------------------
// cpa_front
// Request decode, direction select and squared length, three stages.
// ----------------------------------------------------------------------------
module cpa_front import cpa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [1:0]                req_type,
  input  logic                      a_fixed,
  input  logic                      b_fixed,
  input  logic signed [W-1:0]       dir_x,
  input  logic signed [W-1:0]       dir_y,
  input  logic signed [W-1:0]       dir_z,
  input  logic [REACH_W-1:0]        reach,
  input  logic signed [W-1:0]       alt_x,
  input  logic signed [W-1:0]       alt_z,
  output logic                      out_vld,
  output item_t                     out_item,
  output logic [SQ_W-1:0]           out_sum
);

  ctl_t                  ctl_next;
  logic [2:0][W-1:0]     vec;
  item_t                 item_next;
  logic                  ax_x, ax_y;

  item_t                 item1, item2;
  logic                  vld1, vld2;
  logic [2:0][SQ_W-1:0]  sq;

  // decode of mode and static flags
  always_comb begin
    ctl_next          = '0;
    ctl_next.box      = (req_type == REQ_BOX);
    ctl_next.fallback = (req_type == REQ_SPHERE_BOX) && dir_x == 0 && dir_y == 0
                        && dir_z == 0;
    ctl_next.skip     = (req_type != REQ_NONE) && a_fixed && b_fixed;
    if (req_type == REQ_NONE || ctl_next.skip) begin
      ctl_next.en_a   = 1'b0;
      ctl_next.en_b   = 1'b0;
    end else if (req_type == REQ_SPHERE) begin
      ctl_next.en_a   = 1'b1;
      ctl_next.en_b   = 1'b1;
      ctl_next.shared = 1'b1;
    end else begin
      ctl_next.en_a   = !a_fixed;
      ctl_next.en_b   = !b_fixed;
      ctl_next.shared = !a_fixed && !b_fixed;
    end
  end

  // direction select: smallest overlap axis, fallback or plain vector
  assign ax_x = (dir_x < dir_y) && (dir_x < dir_z);
  assign ax_y = !ax_x && (dir_y < dir_z);

  always_comb begin
    if (ctl_next.box) begin
      vec[0] = ax_x ? dir_x : '0;
      vec[1] = ax_y ? dir_y : '0;
      vec[2] = (!ax_x && !ax_y) ? dir_z : '0;
    end else if (ctl_next.fallback) begin
      vec[0] = alt_x;
      vec[1] = '0;
      vec[2] = alt_z;
    end else begin
      vec[0] = dir_x;
      vec[1] = dir_y;
      vec[2] = dir_z;
    end
    item_next.ctl   = ctl_next;
    item_next.reach = reach;
    for (int i = 0; i < 3; i++) begin
      item_next.neg[i] = vec[i][W-1];
      item_next.mag[i] = vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    item1 <= item_next;
    item2 <= item1;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= SQ_W'(item1.mag[i]) * SQ_W'(item1.mag[i]);
    end
    out_item <= item2;
    out_sum  <= sq[0] + sq[1] + sq[2];
  end

endmodule

// ===== hdl/cpa_sqrt.sv =====
// ----------------------------------------------------------------------------
// cpa_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cpa_sqrt import cpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  item_t             in_item,
  input  logic [SQ_W-1:0]   in_sum,
  output logic              out_vld,
  output item_t             out_item,
  output logic [LEN_W-1:0]  out_len
);

  logic [SQ_W-1:0] rem  [0:SQRT_LAT];
  logic [SQ_W-1:0] res  [0:SQRT_LAT];
  item_t           item [0:SQRT_LAT];
  logic            vld  [0:SQRT_LAT];

  assign rem[0]  = in_sum;
  assign res[0]  = '0;
  assign item[0] = in_item;
  assign vld[0]  = in_vld;

  // one trial subtract per stage
  for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_LAT - 1 - s));
    logic [SQ_W-1:0] trial;
    assign trial = res[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      item[s+1] <= item[s];
      if (rem[s] >= trial) begin
        rem[s+1] <= rem[s] - trial;
        res[s+1] <= (res[s] >> 1) + BIT;
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= res[s] >> 1;
      end
    end
  end

  assign out_vld  = vld[SQRT_LAT];
  assign out_item = item[SQRT_LAT];
  assign out_len  = res[SQRT_LAT][LEN_W-1:0];

endmodule

// ===== hdl/cpa_div.sv =====
// ----------------------------------------------------------------------------
// cpa_div
// Pipelined restoring divider lane with overflow flag, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module cpa_div import cpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  tag_t              in_tag,
  output logic              out_vld,
  output logic [Q_W-1:0]    quo,
  output logic              ovf,
  output tag_t              out_tag
);

  localparam int CMP_W = DEN_W + Q_W;

  logic [NUM_W-1:0] rem  [0:Q_W];
  logic [Q_W-1:0]   qacc [0:Q_W];
  logic [DEN_W-1:0] dv   [0:Q_W];
  logic             of   [0:Q_W];
  tag_t             tg   [0:Q_W];
  logic             vld  [0:Q_W];

  // first stage: quotient too wide for the kept bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= num;
    qacc[0] <= '0;
    dv[0]   <= den;
    of[0]   <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
    tg[0]   <= in_tag;
  end

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int QB = Q_W - 1 - s;
    logic [CMP_W-1:0] dsh;
    assign dsh = CMP_W'(dv[s]) << QB;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      of[s+1] <= of[s];
      tg[s+1] <= tg[s];
      if (CMP_W'(rem[s]) >= dsh) begin
        rem[s+1]  <= rem[s] - dsh[NUM_W-1:0];
        qacc[s+1] <= qacc[s] | (Q_W'(1) << QB);
      end else begin
        rem[s+1]  <= rem[s];
        qacc[s+1] <= qacc[s];
      end
    end
  end

  assign out_vld = vld[Q_W];
  assign quo     = qacc[Q_W];
  assign ovf     = of[Q_W];
  assign out_tag = tg[Q_W];

endmodule

// ===== hdl/collision_push_apart.sv =====
// ----------------------------------------------------------------------------
// collision_push_apart
// Penetration resolution for one collider pair per transfer.
// ----------------------------------------------------------------------------
// A pair is taken on every clock where start is high; busy stays low, so a
// new pair may follow in the very next cycle. The result appears on the
// move and skipped ports with done high for one cycle, in transfer order.
// A pair passes the front stages, the bit-per-stage square root (32
// stages), the middle stages, the bit-per-stage dividers (34 stages) and
// the output register; the receiver cannot stall the pipeline.
module collision_push_apart import cpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic                  a_fixed,
  input  logic                  b_fixed,
  input  logic signed [W-1:0]   dir_x,
  input  logic signed [W-1:0]   dir_y,
  input  logic signed [W-1:0]   dir_z,
  input  logic [REACH_W-1:0]    reach,
  input  logic signed [W-1:0]   alt_x,
  input  logic signed [W-1:0]   alt_z,
  output logic                  done,
  output logic signed [W-1:0]   move_a_x,
  output logic signed [W-1:0]   move_a_y,
  output logic signed [W-1:0]   move_a_z,
  output logic signed [W-1:0]   move_b_x,
  output logic signed [W-1:0]   move_b_y,
  output logic signed [W-1:0]   move_b_z,
  output logic                  skipped
);

  localparam int DEPTH_W = LEN_W + 2;

  logic                  f_vld, s_vld;
  item_t                 f_item, s_item;
  logic [SQ_W-1:0]       f_sum;
  logic [LEN_W-1:0]      s_len;

  // middle stage 1 registers
  logic                  m1_vld;
  item_t                 m1_item;
  logic                  m1_zero;
  logic                  m1_dneg;
  logic [W-1:0]          m1_dmag;
  logic [DEN_W-1:0]      m1_den;

  // middle stage 2 registers
  logic                  m2_vld;
  item_t                 m2_item;
  logic                  m2_zero;
  logic                  m2_dneg;
  logic [DEN_W-1:0]      m2_den;
  logic [2:0][NUM_W-1:0] m2_prod;

  // middle stage 3 registers
  logic                  m3_vld;
  logic [2:0][NUM_W-1:0] m3_num;
  logic [DEN_W-1:0]      m3_den;
  tag_t [2:0]            m3_tag;

  logic [2:0]            d_vld;
  logic [2:0][Q_W-1:0]   d_quo;
  logic [2:0]            d_ovf;
  tag_t [2:0]            d_tag;

  logic [LEN_W-1:0]           len_eff;
  logic signed [DEPTH_W-1:0]  depth;
  logic [2:0][W-1:0]          mv_a, mv_b;

  assign busy = 1'b0;

  cpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start && !busy),
    .req_type (req_type),
    .a_fixed  (a_fixed),
    .b_fixed  (b_fixed),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .reach    (reach),
    .alt_x    (alt_x),
    .alt_z    (alt_z),
    .out_vld  (f_vld),
    .out_item (f_item),
    .out_sum  (f_sum)
  );

  cpa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_item  (f_item),
    .in_sum   (f_sum),
    .out_vld  (s_vld),
    .out_item (s_item),
    .out_len  (s_len)
  );

  // depth and divisor; box pushes use unit length and unit depth
  always_comb begin
    len_eff = s_item.ctl.box ? LEN_W'(1) : s_len;
    if (s_item.ctl.box) begin
      depth = DEPTH_W'(1);
    end else if (s_item.ctl.fallback) begin
      depth = DEPTH_W'(s_item.reach);
    end else begin
      depth = DEPTH_W'(s_item.reach) - DEPTH_W'(s_len);
    end
  end

  // valid bits of the middle stages
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
    end else begin
      m1_vld <= s_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
    end
  end

  // depth, product and rounding bias
  always_ff @(posedge clk) begin
    m1_item <= s_item;
    m1_zero <= (len_eff == '0);
    m1_dneg <= depth[DEPTH_W-1];
    m1_dmag <= depth[DEPTH_W-1] ? W'(-depth) : W'(depth);
    if (len_eff == '0) begin
      m1_den <= DEN_W'(1);
    end else if (s_item.ctl.shared) begin
      m1_den <= {len_eff, 1'b0};
    end else begin
      m1_den <= {1'b0, len_eff};
    end

    m2_item <= m1_item;
    m2_zero <= m1_zero;
    m2_dneg <= m1_dneg;
    m2_den  <= m1_den;
    for (int i = 0; i < 3; i++) begin
      m2_prod[i] <= NUM_W'(m1_item.mag[i]) * NUM_W'(m1_dmag);
    end

    m3_den <= m2_den;
    for (int i = 0; i < 3; i++) begin
      m3_num[i]      <= m2_prod[i] + NUM_W'(m2_den >> 1);
      m3_tag[i].sgn  <= m2_item.neg[i] ^ m2_dneg;
      m3_tag[i].en_a <= m2_item.ctl.en_a && !m2_zero;
      m3_tag[i].en_b <= m2_item.ctl.en_b && !m2_zero;
      m3_tag[i].skip <= m2_item.ctl.skip;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cpa_div u_div (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (m3_vld),
      .num     (m3_num[i]),
      .den     (m3_den),
      .in_tag  (m3_tag[i]),
      .out_vld (d_vld[i]),
      .quo     (d_quo[i]),
      .ovf     (d_ovf[i]),
      .out_tag (d_tag[i])
    );
  end

  // sign and saturation; object a takes the opposite sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic big_pos, big_neg;
      logic [W-1:0] pos, ngv;
      big_pos = d_ovf[i] || (d_quo[i] > Q_W'(SAT_MAX));
      big_neg = d_ovf[i] || (d_quo[i] > Q_W'(SAT_MIN));
      pos     = big_pos ? SAT_MAX : d_quo[i][W-1:0];
      ngv     = big_neg ? SAT_MIN : (~d_quo[i][W-1:0] + 1'b1);
      mv_b[i] = !d_tag[i].en_b ? '0 : (d_tag[i].sgn ? ngv : pos);
      mv_a[i] = !d_tag[i].en_a ? '0 : (d_tag[i].sgn ? pos : ngv);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    move_a_x <= mv_a[0];
    move_a_y <= mv_a[1];
    move_a_z <= mv_a[2];
    move_b_x <= mv_b[0];
    move_b_y <= mv_b[1];
    move_b_z <= mv_b[2];
    skipped  <= d_tag[0].skip;
  end

  // every result traces back to a matching earlier transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without matching transfer");

  // a skipped pair moves nothing
  a_skip_still: assert property (@(posedge clk) disable iff (rst)
    done && skipped |-> move_a_x == 0 && move_a_y == 0 && move_a_z == 0
      && move_b_x == 0 && move_b_y == 0 && move_b_z == 0)
    else $error("skipped pair has nonzero move");

  // the undefined request gives zero moves and no skip
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(start, LATENCY) && $past(req_type, LATENCY) == REQ_NONE
      |-> !skipped && move_a_x == 0 && move_b_x == 0 && move_a_y == 0
      && move_b_y == 0 && move_a_z == 0 && move_b_z == 0)
    else $error("undefined request produced a move");

  // lanes run in lock step
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    d_vld[0] == d_vld[1] && d_vld[1] == d_vld[2])
    else $error("divider lanes out of step");

endmodule
